/* src/sha1_hash_engine_top_defines.svh */
// Assertion macros for the SHA-1 engine.
`ifndef SHA1_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA1_HASH_ENGINE_TOP_DEFINES_SVH

// Implication checked every clock outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sha1_pkg.sv */
package sha1_pkg;

    localparam int NUM_ROUNDS = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS = 5;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       finish;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha1_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } sha1_state_t;

    // Control to the round unit.
    typedef struct packed {
        logic start;
        logic init;
    } sha1_core_ctl_t;

    // Status from the round unit.
    typedef struct packed {
        logic busy;
        logic done;
    } sha1_core_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

/* src/sha1_hash_engine_top.sv */
// SHA-1 byte-stream engine on one shared round unit (80 rounds, one per cycle).
// Input: a byte that leaves its block unfilled is taken while idle; the 64th byte
// of a block holds the input through start, 80 rounds, add and done.
// Output: the first digest word shows once the one or two final blocks are compressed (after
// one more block if the finishing byte fills one); then 5 words, 1 per cycle with m_ready high.
// Reset (aresetn low, synchronous) loads the IV, clears buffer, count and length.
module sha1_hash_engine_top
    import sha1_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sha1_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sha1_out_t m_data
);

`include "sha1_hash_engine_top_defines.svh"

    sha1_state_t state_reg, state_next;

    logic [31:0] buf_reg [BLOCK_WORDS];
    logic [31:0] buf_next [BLOCK_WORDS];
    logic [5:0]  cnt_reg;
    logic [63:0] len_reg;
    logic        fin_reg;     // finish pending behind a block compression
    logic        pad_two_reg; // padding needs a second block
    logic [2:0]  idx_reg;
    logic        fired_reg;   // compression issued in this state

    sha1_core_ctl_t ctl;
    sha1_core_sts_t sts;
    logic [BLOCK_WORDS*32-1:0] blk_flat;
    logic [HASH_WORDS*32-1:0]  hash_flat;

    logic       accept;
    logic       out_fire;
    logic       last_fire;
    logic [5:0] fin_pos;      // pad position for a finish taken in idle
    assign accept    = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign last_fire = out_fire && m_data.last_word;
    assign fin_pos   = s_data.byte_present ? cnt_reg + 6'd1 : cnt_reg;

    always_comb begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            blk_flat[(BLOCK_WORDS-1-i)*32 +: 32] = buf_reg[i];
        end
    end

    sha1_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .block   (blk_flat),
        .sts     (sts),
        .hash    (hash_flat)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.byte_present && cnt_reg == 6'd63) begin
                        state_next = ST_ABSORB;
                    end else if (s_data.finish) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ABSORB: begin
                if (sts.done) begin
                    state_next = fin_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (sts.done) begin
                    state_next = pad_two_reg ? ST_LEN : ST_EMIT;
                end
            end
            ST_LEN: begin
                if (sts.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_fire && idx_reg == 3'd4) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        m_valid  = (state_reg == ST_EMIT);
        ctl.init = (state_reg == ST_EMIT) && m_ready && idx_reg == 3'd4;
        ctl.start = 1'b0;
        case (state_reg)
            ST_ABSORB, ST_PAD, ST_LEN: ctl.start = !fired_reg;
            default: ctl.start = 1'b0;
        endcase
        m_data.digest_word = hash_flat[(HASH_WORDS-1-32'(idx_reg))*32 +: 32];
        m_data.word_index  = idx_reg;
        m_data.last_word   = (idx_reg == 3'd4);
    end

    // One buffer word with 0x80 at lane pos and zeros in every later lane.
    function automatic logic [31:0] pad_word(input logic [31:0] w, input int wi,
                                             input logic [5:0] pos);
        logic [31:0] r;
        r = w;
        for (int j = 0; j < 4; j++) begin
            if (4*wi + j == int'(pos)) begin
                r[24-8*j +: 8] = PAD_BYTE;
            end else if (4*wi + j > int'(pos)) begin
                r[24-8*j +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

    // Block buffer update: byte lanes, padding, length words and clearing after the digest.
    always_comb begin
        logic [63:0] total;
        buf_next = buf_reg;
        total    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.byte_present) begin
                        buf_next[cnt_reg[5:2]][24-8*cnt_reg[1:0] +: 8] = s_data.data_byte;
                    end
                    if (s_data.finish && !(s_data.byte_present && cnt_reg == 6'd63)) begin
                        total = len_reg + {55'd0, fin_pos, 3'd0};
                        for (int i = 0; i < BLOCK_WORDS; i++) begin
                            buf_next[i] = pad_word(buf_next[i], i, fin_pos);
                        end
                        if (fin_pos < 6'd56) begin
                            buf_next[14] = total[63:32];
                            buf_next[15] = total[31:0];
                        end
                    end
                end
            end
            ST_ABSORB: begin
                if (sts.done && fin_reg) begin
                    total = len_reg + BLOCK_BITS;
                    for (int i = 0; i < BLOCK_WORDS; i++) begin
                        buf_next[i] = pad_word(buf_next[i], i, 6'd0);
                    end
                    buf_next[14] = total[63:32];
                    buf_next[15] = total[31:0];
                end
            end
            ST_PAD: begin
                // Second final block: zeros and the length (count still holds the pad lane).
                if (sts.done && pad_two_reg) begin
                    total = len_reg + {55'd0, cnt_reg, 3'd0};
                    for (int i = 0; i < 14; i++) begin
                        buf_next[i] = '0;
                    end
                    buf_next[14] = total[63:32];
                    buf_next[15] = total[31:0];
                end
            end
            ST_EMIT: begin
                if (out_fire && idx_reg == 3'd4) begin
                    for (int i = 0; i < BLOCK_WORDS; i++) begin
                        buf_next[i] = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            len_reg     <= '0;
            fin_reg     <= 1'b0;
            pad_two_reg <= 1'b0;
            idx_reg     <= '0;
            fired_reg   <= 1'b0;
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                buf_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                buf_reg[i] <= buf_next[i];
            end
            if (state_next != state_reg) begin
                fired_reg <= 1'b0;
            end else if (ctl.start) begin
                fired_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fin_reg <= s_data.finish;
                        if (s_data.byte_present) begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                        if (s_data.finish && !(s_data.byte_present && cnt_reg == 6'd63)) begin
                            pad_two_reg <= (fin_pos >= 6'd56);
                        end
                    end
                end
                ST_ABSORB: begin
                    if (sts.done) begin
                        len_reg <= len_reg + BLOCK_BITS;
                        if (fin_reg) begin
                            pad_two_reg <= 1'b0;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_fire) begin
                        if (idx_reg == 3'd4) begin
                            idx_reg <= '0;
                            cnt_reg <= '0;
                            len_reg <= '0;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `SHA_ASSERT_IMP(a_no_in_busy, aclk, aresetn, sts.busy, !s_ready, "input taken while hashing")
    `SHA_ASSERT_IMP(a_out_only_emit, aclk, aresetn, m_valid, !sts.busy, "output while hashing")
    `SHA_ASSERT_NXT(a_last_idle, aclk, aresetn, last_fire, s_ready && cnt_reg == 6'd0, "no idle")
    `SHA_ASSERT_IMP(a_idx_range, aclk, aresetn, m_valid, idx_reg <= 3'd4, "word index out of range")

endmodule

/* src/sha1_core.sv */
module sha1_core
    import sha1_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha1_core_ctl_t        ctl,
    input  logic [BLOCK_WORDS*32-1:0] block,
    output sha1_core_sts_t        sts,
    output logic [HASH_WORDS*32-1:0] hash
);

    logic [31:0] h_reg [HASH_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [BLOCK_WORDS];
    logic [6:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] f_val, k_val, t_val, w_new;

    always_comb begin
        if (rnd_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end else if (rnd_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (rnd_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = rotl(a_reg, 5) + f_val + e_reg + k_val + w_reg[0];
        w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.init) begin
            h_reg[0] <= IV0;
            h_reg[1] <= IV1;
            h_reg[2] <= IV2;
            h_reg[3] <= IV3;
            h_reg[4] <= IV4;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                a_reg <= h_reg[0];
                b_reg <= h_reg[1];
                c_reg <= h_reg[2];
                d_reg <= h_reg[3];
                e_reg <= h_reg[4];
                for (int i = 0; i < BLOCK_WORDS; i++) begin
                    w_reg[i] <= block[(BLOCK_WORDS-1-i)*32 +: 32];
                end
            end else if (busy_reg) begin
                if (rnd_reg == 7'(NUM_ROUNDS)) begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    a_reg <= t_val;
                    b_reg <= a_reg;
                    c_reg <= rotl(b_reg, 30);
                    d_reg <= c_reg;
                    e_reg <= d_reg;
                    for (int i = 0; i < BLOCK_WORDS-1; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[BLOCK_WORDS-1] <= w_new;
                    rnd_reg <= rnd_reg + 7'd1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign hash = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

endmodule
